// ===== src/rlbe_pkg.sv =====
// shared types and constants of the rgb led bit encoder
`default_nettype none
package rlbe_pkg;

  localparam int BITS_PER_PIXEL = 24;
  localparam int CNT_W          = 5;
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(BITS_PER_PIXEL - 1);
  localparam logic [CNT_W-1:0] GAP_SLOT = CNT_W'(BITS_PER_PIXEL);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_BRIGHTNESS   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE_ENABLE = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DUTY_ONE     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DUTY_ZERO    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_RESET_SLOTS  = 3'd4;

  localparam logic [7:0]  BRIGHTNESS_RST   = 8'd45;
  localparam logic        SCALE_ENABLE_RST = 1'b1;
  localparam logic [15:0] DUTY_ONE_RST     = 16'd140;
  localparam logic [15:0] DUTY_ZERO_RST    = 16'd70;
  localparam logic [7:0]  RESET_SLOTS_RST  = 8'd50;

  localparam logic [5:0]  FULL_SCALE = 6'd45;
  localparam logic [10:0] RECIP_45   = 11'd1456;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  typedef struct packed {
    logic [7:0]  brightness;
    logic        scale_enable;
    logic [15:0] duty_one;
    logic [15:0] duty_zero;
    logic [7:0]  reset_slots;
  } cfg_t;

  typedef struct packed {
    logic [BITS_PER_PIXEL-1:0] word;
    logic                      last_pixel;
  } queue_entry_t;

endpackage
`default_nettype wire

// ===== src/rlbe_ifs.sv =====
// channel interfaces of the rgb led bit encoder
`default_nettype none
interface rlbe_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_pixel;
  modport source (output valid, red, green, blue, last_pixel, input ready);
  modport sink (input valid, red, green, blue, last_pixel, output ready);
endinterface

interface rlbe_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] duty;
  logic [7:0]  slot_count;
  logic        last;
  modport source (output valid, duty, slot_count, last, input ready);
  modport sink (input valid, duty, slot_count, last, output ready);
endinterface

interface rlbe_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rlbe_pkg::CFG_ADDR_W-1:0] index;
  logic [rlbe_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/rlbe_front.sv =====
// front end: accepts pixels, scales the channels and packs the grb word
`default_nettype none
module rlbe_front (
  input  wire                     clk,
  input  wire                     rst,
  input  rlbe_pkg::cfg_t          cfg,
  rlbe_pixel_if.sink              pixel,
  output logic                    out_valid,
  input  wire                     out_ready,
  output rlbe_pkg::queue_entry_t  out_entry
);
  import rlbe_pkg::*;

  // channel order in the word: green, red, blue
  logic        v1, v2, v3;
  logic        en;
  logic [5:0]  bright_eff;
  logic [13:0] prod [3];
  logic [13:0] prod2 [3];
  logic [7:0]  quot0 [3];
  logic [24:0] recip [3];
  logic [13:0] rem [3];
  logic [7:0]  quot [3];
  logic [7:0]  chan [3];
  logic        last1, last2;

  assign en          = !v3 || out_ready;
  assign pixel.ready = en;
  assign out_valid   = v3;

  always_comb begin
    if (!cfg.scale_enable) begin
      bright_eff = FULL_SCALE;
    end else if (cfg.brightness > 8'(FULL_SCALE)) begin
      bright_eff = FULL_SCALE;
    end else begin
      bright_eff = cfg.brightness[5:0];
    end
    chan[0] = pixel.green;
    chan[1] = pixel.red;
    chan[2] = pixel.blue;
    for (int i = 0; i < 3; i++) begin
      recip[i] = 25'(prod[i]) * 25'(RECIP_45);
      rem[i]   = prod2[i] - 14'(quot0[i] * FULL_SCALE);
      quot[i]  = (rem[i] >= 14'(FULL_SCALE)) ? quot0[i] + 8'd1 : quot0[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= pixel.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod[i]  <= 14'(chan[i] * bright_eff);
        prod2[i] <= prod[i];
        quot0[i] <= recip[i][23:16];
      end
      last1                <= pixel.last_pixel;
      last2                <= last1;
      out_entry.word       <= {quot[0], quot[1], quot[2]};
      out_entry.last_pixel <= last2;
    end
  end

endmodule
`default_nettype wire

// ===== src/rlbe_queue.sv =====
// short queue between front end and bit serialiser
`default_nettype none
module rlbe_queue #(
  parameter int DEPTH = rlbe_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  rlbe_pkg::queue_entry_t  in_entry,
  output logic                    out_valid,
  input  wire                     out_ready,
  output rlbe_pkg::queue_entry_t  out_entry
);
  import rlbe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(DEPTH + 1);

  queue_entry_t       entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W_Q-1:0] count;
  logic               push, pop;

  assign in_ready  = count != CNT_W_Q'(DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W_Q'(DEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a lone push");

endmodule
`default_nettype wire

// ===== src/rlbe_back.sv =====
// back end: serialises each word into duty results and the latch gap
`default_nettype none
module rlbe_back (
  input  wire                     clk,
  input  wire                     rst,
  input  rlbe_pkg::cfg_t          cfg,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  rlbe_pkg::queue_entry_t  in_entry,
  rlbe_result_if.source           result
);
  import rlbe_pkg::*;

  logic                      busy;
  logic [CNT_W-1:0]          cnt;
  logic [BITS_PER_PIXEL-1:0] word;
  logic                      last_pixel;
  logic                      out_valid;
  logic                      out_load;
  logic                      emit;
  logic                      final_emit;
  logic                      gap;
  logic [15:0]               duty_next;
  logic [7:0]                slots_next;
  logic                      last_next;

  assign gap        = last_pixel && (cfg.reset_slots != 8'd0);
  assign out_load   = !out_valid || result.ready;
  assign emit       = busy && out_load;
  assign final_emit = emit && (((cnt == LAST_BIT) && !gap) || (cnt == GAP_SLOT));
  assign in_ready   = !busy || final_emit;
  assign result.valid = out_valid;

  always_comb begin
    if (cnt == GAP_SLOT) begin
      duty_next  = 16'd0;
      slots_next = cfg.reset_slots;
      last_next  = 1'b1;
    end else begin
      duty_next  = word[BITS_PER_PIXEL-1] ? cfg.duty_one : cfg.duty_zero;
      slots_next = 8'd1;
      last_next  = (cnt == LAST_BIT) && last_pixel && !gap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (final_emit) begin
        busy <= 1'b0;
      end else if (emit) begin
        cnt <= cnt + 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word       <= in_entry.word;
      last_pixel <= in_entry.last_pixel;
    end else if (emit) begin
      word <= word << 1;
    end
    if (emit) begin
      result.duty       <= duty_next;
      result.slot_count <= slots_next;
      result.last       <= last_next;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt <= GAP_SLOT)
    else $error("bit counter beyond the gap slot");

  a_gap_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.slot_count != 8'd1 |-> result.duty == 16'd0 && result.last)
    else $error("multi-slot result is not a closing gap");

endmodule
`default_nettype wire

// ===== src/rgb_led_bit_encoder_unit.sv =====
// top level of the rgb led bit encoder
`default_nettype none
// Takes one pixel (red, green, blue, last_pixel) per transfer, optionally
// scales each channel by min(brightness, 45)/45, packs it green-red-blue and
// sends 24 duty results, msb first, one per clock while result.ready holds.
// After a last pixel a gap result (duty 0, reset_slots slots) follows unless
// reset_slots is 0. A pixel gives 24 results, 25 when it closes a frame with
// a gap; a three-stage scaling pipeline plus a short queue keep the next
// pixel ready behind the output register. Configuration writes are always
// ready and take effect on the next clock.
module rgb_led_bit_encoder_unit #(
  parameter int QUEUE_DEPTH = rlbe_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire            clk,
  input  wire            rst,
  rlbe_cfg_if.sink       cfg,
  rlbe_pixel_if.sink     pixel,
  rlbe_result_if.source  result
);
  import rlbe_pkg::*;

  cfg_t         cfg_regs;
  logic         front_valid, front_ready;
  queue_entry_t front_entry;
  logic         queue_valid, queue_ready;
  queue_entry_t queue_entry;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.brightness   <= BRIGHTNESS_RST;
      cfg_regs.scale_enable <= SCALE_ENABLE_RST;
      cfg_regs.duty_one     <= DUTY_ONE_RST;
      cfg_regs.duty_zero    <= DUTY_ZERO_RST;
      cfg_regs.reset_slots  <= RESET_SLOTS_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_BRIGHTNESS:   cfg_regs.brightness   <= cfg.data[7:0];
        REG_SCALE_ENABLE: cfg_regs.scale_enable <= cfg.data[0];
        REG_DUTY_ONE:     cfg_regs.duty_one     <= cfg.data;
        REG_DUTY_ZERO:    cfg_regs.duty_zero    <= cfg.data;
        REG_RESET_SLOTS:  cfg_regs.reset_slots  <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  rlbe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .pixel     (pixel),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_entry (front_entry)
  );

  rlbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_entry  (front_entry),
    .out_valid (queue_valid),
    .out_ready (queue_ready),
    .out_entry (queue_entry)
  );

  rlbe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_regs),
    .in_valid (queue_valid),
    .in_ready (queue_ready),
    .in_entry (queue_entry),
    .result   (result)
  );

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// testbench for the rgb led bit encoder: directed table, then random frames, checked slot by slot
module tb_top;
  import rlbe_pkg::*;

  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int TAIL_CYCLES      = 40;
  localparam int PRINT_LIMIT      = 50;
  localparam int IDLE_PCT         = 25;
  localparam int PHASES           = 9;
  localparam int PIXELS_PER_PHASE = 50;
  localparam int MAX_FRAME        = 6;

  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_FIRST = REG_RESET_SLOTS + 1'b1;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LAST  = '1;

  typedef struct packed {
    logic [15:0] duty;
    logic [7:0]  slot_count;
    logic        last;
  } led_slot_t;

  typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_ADDR_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic                  last_pixel;
    logic                  typed;
    logic [23:0]           word;
  } row_t;

  logic clk;
  logic rst;
  bit   steady_run;
  int   mismatches;
  int   slot_index;

  // register mirror
  logic [7:0]  mirror_brightness;
  logic        mirror_scale;
  logic [15:0] mirror_duty_one;
  logic [15:0] mirror_duty_zero;
  logic [7:0]  mirror_gap;

  led_slot_t expected_slots [$];

  rlbe_cfg_if    cfg_bus ();
  rlbe_pixel_if  pixel_bus ();
  rlbe_result_if result_bus ();

  rgb_led_bit_encoder_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .pixel  (pixel_bus),
    .result (result_bus)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] dim_channel(logic [7:0] level);
    int unsigned gain;
    gain = 32'((mirror_brightness > 8'(FULL_SCALE)) ? 8'(FULL_SCALE) : mirror_brightness);
    return 8'((32'(level) * gain) / 32'(FULL_SCALE));
  endfunction

  function automatic logic [23:0] grb_word(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    if (mirror_scale) return {dim_channel(g), dim_channel(r), dim_channel(b)};
    return {g, r, b};
  endfunction

  task automatic queue_pixel_slots(logic [23:0] word, logic last_pixel);
    led_slot_t slot;
    for (int k = BITS_PER_PIXEL - 1; k >= 0; k--) begin
      slot.duty       = word[k] ? mirror_duty_one : mirror_duty_zero;
      slot.slot_count = 8'd1;
      slot.last       = last_pixel && k == 0 && mirror_gap == '0;
      expected_slots.push_back(slot);
    end
    if (last_pixel && mirror_gap != '0) begin
      slot.duty       = '0;
      slot.slot_count = mirror_gap;
      slot.last       = 1'b1;
      expected_slots.push_back(slot);
    end
  endtask

  function automatic row_t pixel_row(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     logic last_pixel);
    row_t row;
    row            = '0;
    row.kind       = ROW_PIXEL;
    row.red        = r;
    row.green      = g;
    row.blue       = b;
    row.last_pixel = last_pixel;
    return row;
  endfunction

  function automatic row_t typed_row(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     logic last_pixel, logic [23:0] word);
    row_t row;
    row       = pixel_row(r, g, b, last_pixel);
    row.typed = 1'b1;
    row.word  = word;
    return row;
  endfunction

  function automatic row_t reg_row(logic [CFG_ADDR_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    row_t row;
    row       = '0;
    row.kind  = ROW_REG;
    row.index = index;
    row.data  = data;
    return row;
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_duty();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_brightness();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'(FULL_SCALE);
      2: return 8'(FULL_SCALE) + 8'd1;
      3: return 8'(FULL_SCALE) - 8'd1;
      4: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_gap();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // waits for the block to drain, then writes one register
  task automatic write_reg(logic [CFG_ADDR_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    pixel_bus.valid <= 1'b0;
    while (expected_slots.size() != 0) @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (index)
      REG_BRIGHTNESS:   mirror_brightness = data[7:0];
      REG_SCALE_ENABLE: mirror_scale      = data[0];
      REG_DUTY_ONE:     mirror_duty_one   = data;
      REG_DUTY_ZERO:    mirror_duty_zero  = data;
      REG_RESET_SLOTS:  mirror_gap        = data[7:0];
      default: ;
    endcase
  endtask

  task automatic send_pixel(row_t row);
    cfg_bus.valid <= 1'b0;
    while (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
      pixel_bus.valid <= 1'b0;
      @(posedge clk);
    end
    pixel_bus.valid      <= 1'b1;
    pixel_bus.red        <= row.red;
    pixel_bus.green      <= row.green;
    pixel_bus.blue       <= row.blue;
    pixel_bus.last_pixel <= row.last_pixel;
    @(posedge clk);
    while (!pixel_bus.ready) @(posedge clk);
    queue_pixel_slots(row.typed ? row.word : grb_word(row.red, row.green, row.blue),
                      row.last_pixel);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("mismatch at slot %0d: %s got %0h want %0h", slot_index, what, got, want);
    mismatches++;
  endtask

  // result sink with random back-pressure
  initial begin
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_bus.ready <= steady_run || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  always @(posedge clk) begin : check_slots
    led_slot_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (expected_slots.size() == 0) begin
        report_mismatch("unexpected transfer, duty", 32'(result_bus.duty), '0);
      end else begin
        want = expected_slots.pop_front();
        if (result_bus.duty !== want.duty)
          report_mismatch("duty", 32'(result_bus.duty), 32'(want.duty));
        if (result_bus.slot_count !== want.slot_count)
          report_mismatch("slot_count", 32'(result_bus.slot_count), 32'(want.slot_count));
        if (result_bus.last !== want.last)
          report_mismatch("last", 32'(result_bus.last), 32'(want.last));
      end
      slot_index++;
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (pixel_bus.valid && pixel_bus.ready) || (cfg_bus.valid && cfg_bus.ready) ||
          (result_bus.valid && result_bus.ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    row_t directed_rows [$];
    row_t row;
    int   left_in_frame;
    logic frame_end;

    mismatches        = 0;
    slot_index        = 0;
    steady_run        = 1'b0;
    mirror_brightness = BRIGHTNESS_RST;
    mirror_scale      = SCALE_ENABLE_RST;
    mirror_duty_one   = DUTY_ONE_RST;
    mirror_duty_zero  = DUTY_ZERO_RST;
    mirror_gap        = RESET_SLOTS_RST;

    rst                  <= 1'b1;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= '0;
    cfg_bus.data         <= '0;
    pixel_bus.valid      <= 1'b0;
    pixel_bus.red        <= '0;
    pixel_bus.green      <= '0;
    pixel_bus.blue       <= '0;
    pixel_bus.last_pixel <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    directed_rows = '{
      // reset settings: full scale, scaling on
      typed_row(8'h00, 8'h00, 8'h00, 1'b0, 24'h000000),
      typed_row(8'hff, 8'hff, 8'hff, 1'b0, 24'hffffff),
      pixel_row(8'h12, 8'h34, 8'h56, 1'b1),
      pixel_row(8'ha5, 8'h5a, 8'hc3, 1'b0),
      // brightness zero blanks every channel
      reg_row(REG_BRIGHTNESS, 16'h0000),
      typed_row(8'hff, 8'h80, 8'h7f, 1'b1, 24'h000000),
      // brightness above full scale saturates
      reg_row(REG_BRIGHTNESS, 16'h00ff),
      typed_row(8'hff, 8'hff, 8'hff, 1'b0, 24'hffffff),
      pixel_row(8'h80, 8'h40, 8'h01, 1'b0),
      reg_row(REG_BRIGHTNESS, 16'h0016),
      pixel_row(8'hff, 8'h00, 8'haa, 1'b0),
      pixel_row(8'h01, 8'h02, 8'h2c, 1'b1),
      // raw colours
      reg_row(REG_SCALE_ENABLE, 16'h0000),
      typed_row(8'h12, 8'h34, 8'h56, 1'b0, 24'h341256),
      typed_row(8'hff, 8'h00, 8'hff, 1'b1, 24'h00ffff),
      // empty latch gap
      reg_row(REG_RESET_SLOTS, 16'h0000),
      typed_row(8'haa, 8'h55, 8'hf0, 1'b1, 24'h55aaf0),
      typed_row(8'h0f, 8'hf0, 8'h3c, 1'b0, 24'hf00f3c),
      reg_row(REG_DUTY_ONE, 16'hffff),
      reg_row(REG_DUTY_ZERO, 16'h0000),
      typed_row(8'h5a, 8'ha5, 8'h81, 1'b1, 24'ha55a81),
      reg_row(REG_RESET_SLOTS, 16'h00ff),
      typed_row(8'h00, 8'hff, 8'h00, 1'b1, 24'hff0000),
      reg_row(REG_DUTY_ONE, 16'h0000),
      reg_row(REG_DUTY_ZERO, 16'hffff),
      typed_row(8'hc3, 8'h3c, 8'h99, 1'b0, 24'h3cc399),
      typed_row(8'h01, 8'h80, 8'hfe, 1'b1, 24'h8001fe),
      // writes to unused indexes are dropped
      reg_row(REG_SPARE_FIRST, 16'hffff),
      reg_row(REG_SPARE_LAST, 16'h0000),
      typed_row(8'h12, 8'h34, 8'h56, 1'b1, 24'h341256),
      // upper data bits are ignored
      reg_row(REG_BRIGHTNESS, 16'h012d),
      reg_row(REG_SCALE_ENABLE, 16'h0003),
      pixel_row(8'h90, 8'h91, 8'h92, 1'b1)
    };

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG)
        write_reg(directed_rows[i].index, directed_rows[i].data);
      else
        send_pixel(directed_rows[i]);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      write_reg(REG_BRIGHTNESS, {8'($urandom), pick_brightness()});
      write_reg(REG_SCALE_ENABLE, 16'($urandom));
      write_reg(REG_DUTY_ONE, pick_duty());
      write_reg(REG_DUTY_ZERO, pick_duty());
      write_reg(REG_RESET_SLOTS, {8'($urandom), pick_gap()});
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_SPARE_FIRST +
                  CFG_ADDR_W'($urandom_range(0, REG_SPARE_LAST - REG_SPARE_FIRST)),
                  16'($urandom));
      steady_run    = (phase == PHASES / 2);
      left_in_frame = $urandom_range(1, MAX_FRAME);
      for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
        left_in_frame--;
        // mostly whole frames, now and then a stray last flag
        frame_end = left_in_frame == 0 || $urandom_range(0, 9) == 0;
        if (left_in_frame == 0) left_in_frame = $urandom_range(1, MAX_FRAME);
        row = pixel_row(pick_level(), pick_level(), pick_level(), frame_end);
        send_pixel(row);
      end
      steady_run = 1'b0;
    end

    pixel_bus.valid <= 1'b0;
    cfg_bus.valid   <= 1'b0;
    while (expected_slots.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
